FILE: rtl/utf8_decode_ascii_fold_assert.svh
// Assertion macros shared by the decoder modules.
// Define ASSERT_OFF to compile every check to nothing.
`ifndef UTF8_DECODE_ASCII_FOLD_ASSERT_SVH
`define UTF8_DECODE_ASCII_FOLD_ASSERT_SVH

`ifndef ASSERT_OFF
// Check prop at every rising clk edge, skipped while rst is high.
`define UDAF_ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("udaf assertion failed");
// Check prop at every rising clk edge, reset included.
`define UDAF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("udaf assertion failed");
`else
`define UDAF_ASSERT_RST(lbl, clk, rst, prop)
`define UDAF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/udaf_pkg.sv
`timescale 1ns / 1ps
package udaf_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned GLYPH_W = 7;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_VAL   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_VAL  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_VAL  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_VAL  = 8'hF0;
  localparam logic [7:0] PAYLOAD6   = 8'h3F;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_NBSP        = 21'h0000A0;
  localparam logic [CP_W-1:0] CP_TIMES       = 21'h0000D7;
  localparam logic [CP_W-1:0] CP_HYPHEN      = 21'h002010;
  localparam logic [CP_W-1:0] CP_NB_HYPHEN   = 21'h002011;
  localparam logic [CP_W-1:0] CP_FIG_DASH    = 21'h002012;
  localparam logic [CP_W-1:0] CP_EN_DASH     = 21'h002013;
  localparam logic [CP_W-1:0] CP_EM_DASH     = 21'h002014;
  localparam logic [CP_W-1:0] CP_HBAR        = 21'h002015;
  localparam logic [CP_W-1:0] CP_LSQUO       = 21'h002018;
  localparam logic [CP_W-1:0] CP_RSQUO       = 21'h002019;
  localparam logic [CP_W-1:0] CP_LDQUO       = 21'h00201C;
  localparam logic [CP_W-1:0] CP_RDQUO       = 21'h00201D;
  localparam logic [CP_W-1:0] CP_MINUS       = 21'h002212;

  localparam int unsigned GLYPH_FIRST = 32;
  localparam int unsigned GLYPH_COUNT = 96;

  localparam logic [GLYPH_W-1:0] GLYPH_SPACE  = 7'd32;
  localparam logic [GLYPH_W-1:0] GLYPH_DQUOTE = 7'd34;
  localparam logic [GLYPH_W-1:0] GLYPH_SQUOTE = 7'd39;
  localparam logic [GLYPH_W-1:0] GLYPH_DASH   = 7'd45;
  localparam logic [GLYPH_W-1:0] GLYPH_QMARK  = 7'd63;
  localparam logic [GLYPH_W-1:0] GLYPH_X      = 7'd120;

  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // queue between front and back
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } req_t;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [GLYPH_W-1:0] glyph_index;
    logic               malformed;
    logic               last_of_run;
  } res_t;

  // One queued input item: an optional replacement for an interrupted
  // sequence, then an optional main character.
  typedef struct packed {
    logic            pre_bad;
    logic            has_main;
    logic            main_bad;
    logic [CP_W-1:0] main_cp;
  } entry_t;

  function automatic logic [GLYPH_W-1:0] fold_glyph(input logic [CP_W-1:0] cp);
    logic [GLYPH_W-1:0] g;
    unique case (cp)
      CP_NBSP:                          g = GLYPH_SPACE;
      CP_HYPHEN, CP_NB_HYPHEN, CP_FIG_DASH,
      CP_EN_DASH, CP_EM_DASH, CP_HBAR,
      CP_MINUS:                         g = GLYPH_DASH;
      CP_LSQUO, CP_RSQUO:               g = GLYPH_SQUOTE;
      CP_LDQUO, CP_RDQUO:               g = GLYPH_DQUOTE;
      CP_TIMES:                         g = GLYPH_X;
      default: begin
        if (cp >= CP_W'(GLYPH_FIRST) && cp < CP_W'(GLYPH_FIRST + GLYPH_COUNT)) begin
          g = cp[GLYPH_W-1:0];
        end else begin
          g = GLYPH_QMARK;
        end
      end
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/utf8_decode_ascii_fold.sv
`timescale 1ns / 1ps
// Channel | Signals                   | Direction | Payload
// req     | req_valid, req_ready, req | in        | req_type, in_byte
// res     | res_valid, res_ready, res | out       | code_point, glyph_index,
//         |                           |           | malformed, last_of_run
//
// One byte is taken per cycle while the front-to-back queue has room.
// Results leave at one per cycle from a registered output while res_ready
// stays high; an item that interrupts a sequence and also yields a character
// holds the back part until both its results are loaded, so the output
// side sets the rate at one result a cycle. An accepted byte is written
// to the queue, then loaded into the output register.
// Reset (synchronous, rst high) clears the decode state, the queue and
// the output valid; no clearing pass is needed.
// A stall on res fills the queue; req_ready drops once it holds four items.
module utf8_decode_ascii_fold (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  udaf_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output udaf_pkg::res_t res
);
  import udaf_pkg::*;

  // front to queue
  logic   push;
  logic   push_ready;
  entry_t push_data;

  // queue to back
  logic   head_valid;
  logic   pop;
  entry_t head;

  // Classify each byte and advance the sequence state; drop items that
  // only open or extend a sequence, queue the rest.
  udaf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Hold decoded items so that a stalled output does not stall input until the queue is full.
  udaf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  // Split each queued item into its one or two result transactions and
  // fold the code point to a glyph.
  udaf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

FILE: rtl/udaf_front.sv
`timescale 1ns / 1ps
`include "utf8_decode_ascii_fold_assert.svh"
module udaf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  udaf_pkg::req_t  req,
  output logic            push,
  input  logic            push_ready,
  output udaf_pkg::entry_t push_data
);
  import udaf_pkg::*;

  logic [1:0]      pending_count, pending_count_next;
  logic [CP_W-1:0] partial_point, partial_point_next;
  logic            take;
  logic            is_cont;
  logic [7:0]      b;

  assign b         = req.in_byte;
  assign req_ready = push_ready;
  assign take      = req_valid && req_ready;
  assign is_cont   = (b & CONT_MASK) == CONT_VAL;

  always_comb begin
    pending_count_next = pending_count;
    partial_point_next = partial_point;
    push_data          = '0;
    if (req.req_type == REQ_FLUSH) begin
      if (pending_count != 2'd0) begin
        push_data.pre_bad  = 1'b1;
        pending_count_next = 2'd0;
        partial_point_next = '0;
      end
    end else if (pending_count != 2'd0 && is_cont) begin
      // append six payload bits, complete when the count runs out
      partial_point_next = {partial_point[CP_W-7:0], b[5:0]};
      pending_count_next = pending_count - 2'd1;
      if (pending_count == 2'd1) begin
        push_data.has_main = 1'b1;
        push_data.main_cp  = partial_point_next;
        partial_point_next = '0;
      end
    end else begin
      // an interrupted sequence is replaced, then the byte starts afresh
      push_data.pre_bad  = pending_count != 2'd0;
      pending_count_next = 2'd0;
      partial_point_next = '0;
      priority if (!b[7]) begin
        push_data.has_main = 1'b1;
        push_data.main_cp  = CP_W'(b);
      end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
        partial_point_next = CP_W'(b & 8'h1F);
        pending_count_next = 2'd1;
      end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
        partial_point_next = CP_W'(b & 8'h0F);
        pending_count_next = 2'd2;
      end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
        partial_point_next = CP_W'(b & 8'h07);
        pending_count_next = 2'd3;
      end else begin
        push_data.has_main = 1'b1;
        push_data.main_bad = 1'b1;
        push_data.main_cp  = REPLACEMENT_CP;
      end
    end
  end

  assign push = take && (push_data.pre_bad || push_data.has_main);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      partial_point <= '0;
    end else if (take) begin
      pending_count <= pending_count_next;
      partial_point <= partial_point_next;
    end
  end

  `UDAF_ASSERT_RST(a_idle_point_clear, clk, rst, (pending_count == 2'd0) |-> (partial_point == '0))

endmodule

FILE: rtl/udaf_queue.sv
`timescale 1ns / 1ps
`include "utf8_decode_ascii_fold_assert.svh"
module udaf_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  udaf_pkg::entry_t push_data,
  output logic             head_valid,
  input  logic             pop,
  output udaf_pkg::entry_t head
);
  import udaf_pkg::*;

  entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QDEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_W'((32'(wr_ptr) + 1) % QDEPTH);
      end
      if (do_pop) begin
        rd_ptr <= QPTR_W'((32'(rd_ptr) + 1) % QDEPTH);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

  `UDAF_ASSERT_RST(a_count_bound, clk, rst, count <= QCNT_W'(QDEPTH))

endmodule

FILE: rtl/udaf_back.sv
`timescale 1ns / 1ps
`include "utf8_decode_ascii_fold_assert.svh"
module udaf_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  udaf_pkg::entry_t head,
  output logic             pop,
  output logic             res_valid,
  input  logic             res_ready,
  output udaf_pkg::res_t   res
);
  import udaf_pkg::*;

  logic second_half, second_half_next;
  logic load;
  logic emit_pre;
  res_t res_next;

  assign load     = head_valid && (!res_valid || res_ready);
  // the replacement goes out first unless it already went
  assign emit_pre = head.pre_bad && !second_half;

  always_comb begin
    second_half_next = second_half;
    pop              = 1'b0;
    if (emit_pre) begin
      res_next.code_point  = REPLACEMENT_CP;
      res_next.malformed   = 1'b1;
      res_next.last_of_run = !head.has_main;
    end else begin
      res_next.code_point  = head.main_cp;
      res_next.malformed   = head.main_bad;
      res_next.last_of_run = 1'b1;
    end
    res_next.glyph_index = fold_glyph(res_next.code_point);
    if (load) begin
      if (emit_pre && head.has_main) begin
        second_half_next = 1'b1;
      end else begin
        second_half_next = 1'b0;
        pop              = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      second_half <= 1'b0;
    end else begin
      second_half <= second_half_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  `UDAF_ASSERT_RST(a_half_has_entry, clk, rst, second_half |-> (head_valid && head.pre_bad && head.has_main))
  `UDAF_ASSERT_RST(a_entry_nonempty, clk, rst, head_valid |-> (head.pre_bad || head.has_main))
  `UDAF_ASSERT_RST(a_res_hold, clk, rst, (res_valid && !res_ready) |=> (res_valid && $stable(res)))

endmodule

FILE: verif/tb_utf8_decode_ascii_fold.sv
`timescale 1ns / 1ps
module tb_utf8_decode_ascii_fold;
  import udaf_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  // Byte stream still to be offered, and characters the decoder owes us.
  req_t pending_bytes[$];
  res_t expected_chars[$];

  // Decoder state as the checker sees it: continuation bytes still owed
  // and the code point gathered so far.
  logic [1:0]      owed_conts = '0;
  logic [CP_W-1:0] partial_cp = '0;

  int bytes_taken = 0;
  int chars_seen = 0;
  int mismatches = 0;
  int send_gap = 0;
  int recv_hold = 0;
  bit long_hold_done = 1'b0;

  // Code points with a special ASCII fold.
  logic [CP_W-1:0] fold_points [13] = '{
    CP_NBSP, CP_TIMES, CP_HYPHEN, CP_NB_HYPHEN, CP_FIG_DASH, CP_EN_DASH,
    CP_EM_DASH, CP_HBAR, CP_LSQUO, CP_RSQUO, CP_LDQUO, CP_RDQUO, CP_MINUS
  };

  utf8_decode_ascii_fold u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Fold a code point to its ASCII glyph: typographic punctuation, NBSP and the times sign to the
  // plain form, codes 0x20 to 0x7F to themselves, everything else to '?'.
  function automatic logic [GLYPH_W-1:0] ascii_fold(input logic [CP_W-1:0] cp);
    case (cp)
      CP_NBSP:                               return GLYPH_SPACE;
      CP_HYPHEN, CP_NB_HYPHEN, CP_FIG_DASH,
      CP_EN_DASH, CP_EM_DASH, CP_HBAR,
      CP_MINUS:                              return GLYPH_DASH;
      CP_LSQUO, CP_RSQUO:                    return GLYPH_SQUOTE;
      CP_LDQUO, CP_RDQUO:                    return GLYPH_DQUOTE;
      CP_TIMES:                              return GLYPH_X;
      default: begin
        if (cp >= GLYPH_FIRST && cp < GLYPH_FIRST + GLYPH_COUNT) return cp[GLYPH_W-1:0];
        return GLYPH_QMARK;
      end
    endcase
  endfunction

  function automatic void queue_char(input logic [CP_W-1:0] cp, input logic bad);
    res_t c;
    c.code_point  = cp;
    c.glyph_index = ascii_fold(cp);
    c.malformed   = bad;
    c.last_of_run = 1'b0;
    expected_chars.push_back(c);
  endfunction

  // Advance the decoder state by one accepted byte transaction and queue
  // the characters it completes (none, one or two).
  task automatic decode_byte(input req_t item);
    int n = 0;
    logic [7:0] b;
    b = item.in_byte;
    if (item.req_type == REQ_FLUSH) begin
      // end of text: a half-built sequence turns into one replacement
      if (owed_conts != 0) begin
        queue_char(REPLACEMENT_CP, 1'b1);
        n++;
        owed_conts = '0;
        partial_cp = '0;
      end
    end else if (owed_conts != 0 && (b & CONT_MASK) == CONT_VAL) begin
      partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
      owed_conts = owed_conts - 2'd1;
      if (owed_conts == 0) begin
        queue_char(partial_cp, 1'b0);
        n++;
        partial_cp = '0;
      end
    end else begin
      // a non-continuation byte breaks an open sequence, then starts afresh
      if (owed_conts != 0) begin
        queue_char(REPLACEMENT_CP, 1'b1);
        n++;
        owed_conts = '0;
        partial_cp = '0;
      end
      if (b < 8'h80) begin
        queue_char(CP_W'(b), 1'b0);
        n++;
      end else if ((b & LEAD2_MASK) == LEAD2_VAL) begin
        partial_cp = CP_W'(b[4:0]);
        owed_conts = 2'd1;
      end else if ((b & LEAD3_MASK) == LEAD3_VAL) begin
        partial_cp = CP_W'(b[3:0]);
        owed_conts = 2'd2;
      end else if ((b & LEAD4_MASK) == LEAD4_VAL) begin
        partial_cp = CP_W'(b[2:0]);
        owed_conts = 2'd3;
      end else begin
        // stray continuation or a lead byte F8..FF
        queue_char(REPLACEMENT_CP, 1'b1);
        n++;
      end
    end
    if (n > 0) expected_chars[expected_chars.size() - 1].last_of_run = 1'b1;
  endtask

  // Mostly back-to-back, sometimes a short pause, rarely a long one; none when calm.
  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    req_t t;
    t.req_type = REQ_DATA;
    t.in_byte  = b;
    pending_bytes.push_back(t);
  endtask

  task automatic push_flush();
    req_t t;
    t.req_type = REQ_FLUSH;
    t.in_byte  = 8'($urandom_range(0, 255));
    pending_bytes.push_back(t);
  endtask

  // Encode cp in len bytes (overlong forms allowed) and push the first
  // keep of them; keep < len leaves a truncated sequence.
  task automatic push_utf8(input logic [CP_W-1:0] cp, input int len, input int keep);
    logic [7:0]      seq [4];
    logic [CP_W-1:0] part;
    case (len)
      1:       seq[0] = {1'b0, cp[6:0]};
      2:       seq[0] = LEAD2_VAL | {3'b000, cp[10:6]};
      3:       seq[0] = LEAD3_VAL | {4'b0000, cp[15:12]};
      default: seq[0] = LEAD4_VAL | {5'b00000, cp[20:18]};
    endcase
    for (int i = 1; i < len; i++) begin
      part = cp >> (6 * (len - 1 - i));
      seq[i] = CONT_VAL | ({2'b00, part[5:0]} & PAYLOAD6);
    end
    for (int i = 0; i < keep; i++) push_byte(seq[i]);
  endtask

  // Random text: mostly well-formed characters of every length, with
  // noise bytes, flushes and truncated sequences mixed in.
  task automatic push_random_text(input int total);
    int r;
    int len;
    while (pending_bytes.size() < total) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        push_byte(8'($urandom_range(0, 127)));
      end else if (r < 52) begin
        push_utf8(CP_W'($urandom_range(0, 'h7FF)), 2, 2);
      end else if (r < 68) begin
        if ($urandom_range(0, 1)) push_utf8(fold_points[$urandom_range(0, 12)], 3, 3);
        else push_utf8(CP_W'($urandom_range(0, 'hFFFF)), 3, 3);
      end else if (r < 82) begin
        push_utf8(CP_W'($urandom_range(0, 'h1FFFFF)), 4, 4);
      end else begin
        case ($urandom_range(0, 3))
          0: push_byte(8'($urandom_range(0, 255)));
          1: push_flush();
          2: begin
            len = $urandom_range(2, 4);
            push_utf8(CP_W'($urandom_range(0, 'h1FFFFF)), len, $urandom_range(1, len - 1));
          end
          default: push_byte(CONT_VAL | 8'($urandom_range(0, 63)));
        endcase
      end
    end
  endtask

  // Compare one result transaction against the oldest expected character.
  task automatic check_char(input res_t got);
    res_t want;
    chars_seen++;
    if (expected_chars.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, none expected, got cp=%h glyph=%0d bad=%b last=%b",
               $time, got.code_point, got.glyph_index, got.malformed, got.last_of_run);
    end else begin
      want = expected_chars.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: mismatch: cp exp %h got %h, glyph exp %0d got %0d, bad exp %b got %b, last exp %b got %b",
                 $time, want.code_point, got.code_point, want.glyph_index, got.glyph_index,
                 want.malformed, got.malformed, want.last_of_run, got.last_of_run);
      end
    end
  endtask

  // Sender: hold the payload until taken, then either pause or offer the
  // next byte. Calm windows run with no pauses at all.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_valid && req_ready) begin
        decode_byte(req);
        bytes_taken++;
      end
      if (req_valid && !req_ready) begin
        // hold: not yet accepted
      end else if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        req <= pending_bytes.pop_front();
        req_valid <= 1'b1;
        send_gap = pick_gap((bytes_taken / 100) % 4 == 1);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each accepted result, stall at random, and once hold
  // off for a long stretch so the decoder queue fills and blocks input.
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (res_valid && res_ready) check_char(res);
      if (recv_hold > 0) begin
        recv_hold--;
        res_ready <= 1'b0;
      end else if (!long_hold_done && chars_seen >= 300) begin
        long_hold_done = 1'b1;
        recv_hold = 200;
        res_ready <= 1'b0;
      end else begin
        recv_hold = pick_gap((chars_seen / 100) % 4 == 2);
        if (recv_hold > 0) begin
          recv_hold--;
          res_ready <= 1'b0;
        end else begin
          res_ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    // directed: byte extremes, stray and invalid bytes, folds, all lengths
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'h80);                    // stray continuation
    push_byte(8'hF8);                    // lead bytes that are never valid
    push_byte(8'hFF);
    push_utf8(CP_NBSP, 2, 2);
    push_utf8(CP_EM_DASH, 3, 3);
    push_utf8(CP_TIMES, 2, 2);
    push_utf8(REPLACEMENT_CP, 3, 3);     // well-formed U+FFFD, not malformed
    push_utf8(21'h01F600, 4, 4);
    push_byte(8'hE2);                    // broken sequence, then 'A'
    push_byte(8'h41);
    push_byte(8'hC3);                    // broken by a new lead byte
    push_byte(8'hE2);
    push_flush();                        // flush the open sequence
    push_flush();                        // flush with nothing open
    push_random_text(1075);

    while (pending_bytes.size() != 0 || req_valid) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    // drain: let any stray extra result show up
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("utf8_decode_ascii_fold test passed");
    end else begin
      $display("utf8_decode_ascii_fold test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("utf8_decode_ascii_fold test failed");
    $finish;
  end

endmodule
